// ===== src/lcdseq_pkg.sv =====
package lcdseq_pkg;

	localparam int QUEUE_DEPTH = 4;

	// input selector codes
	localparam logic [1:0] CMD_WRITE_CMD  = 2'd0;
	localparam logic [1:0] CMD_WRITE_DATA = 2'd1;
	localparam logic [1:0] CMD_SET_CURSOR = 2'd2;
	localparam logic [1:0] CMD_NONE       = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE_PULSE = 2'd0;
	localparam logic [1:0] REG_NIBBLE_GAP   = 2'd1;
	localparam logic [1:0] REG_SETTLE       = 2'd2;
	localparam logic [1:0] REG_POWER_ON     = 2'd3;

	localparam logic [9:0]  RST_ENABLE_PULSE = 10'd1;
	localparam logic [15:0] RST_NIBBLE_GAP   = 16'd200;
	localparam logic [15:0] RST_SETTLE       = 16'd2000;
	localparam logic [15:0] RST_POWER_ON     = 16'd2000;

	// step numbering: power-on wait, 24 init nibble steps, final wait, 4 byte steps
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_POWER_ON   = 5'd0;
	localparam logic [STEP_W-1:0] STEP_FINAL_WAIT = 5'd25;
	localparam logic [STEP_W-1:0] STEP_BYTE0      = 5'd26;
	localparam logic [STEP_W-1:0] STEP_LAST       = 5'd29;

	// nibble phases of one byte
	localparam logic [1:0] PH_HI_EN  = 2'd0;
	localparam logic [1:0] PH_HI_GAP = 2'd1;
	localparam logic [1:0] PH_LO_EN  = 2'd2;
	localparam logic [1:0] PH_LO_SET = 2'd3;

	localparam logic [7:0] CURSOR_BASE = 8'h80;

	typedef struct packed {
		logic       init;
		logic       rs;
		logic [7:0] data;
	} lcdseq_entry_t;

	typedef struct packed {
		logic          valid;
		lcdseq_entry_t entry;
	} lcdseq_wr_t;

	typedef struct packed {
		logic [9:0]  pulse;
		logic [15:0] gap;
		logic [15:0] settle;
		logic [15:0] power;
	} lcdseq_timing_t;

	typedef struct packed {
		logic              emit;
		logic              busy;
		logic [STEP_W-1:0] step;
	} lcdseq_status_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h33;
			3'd1:    r = 8'h32;
			3'd2:    r = 8'h28;
			3'd3:    r = 8'h0C;
			3'd4:    r = 8'h06;
			3'd5:    r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/lcdseq_front.sv =====
module lcdseq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 q_full,
	input  logic [1:0]           cmd,
	input  logic [7:0]           value,
	input  logic                 row,
	input  logic [5:0]           col,
	output lcdseq_pkg::lcdseq_wr_t wr,
	output logic                 initialized
);
	import lcdseq_pkg::*;

	logic initialized_q;
	logic take;

	assign take = push && !q_full && (cmd != CMD_NONE);

	always_comb begin
		wr.valid      = take;
		wr.entry.init = !initialized_q;
		case (cmd)
			CMD_WRITE_DATA: begin
				wr.entry.rs   = 1'b1;
				wr.entry.data = value;
			end
			CMD_SET_CURSOR: begin
				wr.entry.rs   = 1'b0;
				wr.entry.data = CURSOR_BASE | {1'b0, row, col};
			end
			default: begin
				wr.entry.rs   = 1'b0;
				wr.entry.data = value;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q <= 1'b0;
		end else if (take) begin
			initialized_q <= 1'b1;
		end
	end

	assign initialized = initialized_q;

endmodule

// ===== src/lcdseq_fifo.sv =====
module lcdseq_fifo #(
	parameter int Depth = lcdseq_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lcdseq_pkg::lcdseq_wr_t    wr,
	input  logic                      rd,
	output lcdseq_pkg::lcdseq_entry_t head,
	output logic                      full,
	output logic                      empty
);
	import lcdseq_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	lcdseq_entry_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr, do_rd;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign do_wr = wr.valid && !full;
	assign do_rd = rd && !empty;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/lcdseq_back.sv =====
module lcdseq_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lcdseq_pkg::lcdseq_entry_t head,
	input  logic                      q_empty,
	output logic                      q_rd,
	input  lcdseq_pkg::lcdseq_timing_t timing,
	input  logic                      pop,
	output logic                      empty,
	output logic                      reg_select,
	output logic                      enable,
	output logic [3:0]                nibble,
	output logic [15:0]               hold_us,
	output logic                      last,
	output lcdseq_pkg::lcdseq_status_t status
);
	import lcdseq_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              rs_q, en_q, last_q;
	logic [3:0]        nib_q;
	logic [15:0]       hold_q;

	logic              out_free, go;
	logic [STEP_W-1:0] s, t, bdiff;
	logic [7:0]        cur_byte;
	logic [1:0]        phase;
	logic              n_rs, n_en;
	logic [3:0]        n_nib;
	logic [15:0]       n_hold;
	logic              is_wait;

	assign out_free = !out_valid_q || pop;
	assign go       = !q_empty && out_free;

	always_comb begin
		s        = busy_q ? step_q : (head.init ? STEP_POWER_ON : STEP_BYTE0);
		t        = s - 1'b1;
		bdiff    = s - STEP_BYTE0;
		is_wait  = (s == STEP_POWER_ON) || (s == STEP_FINAL_WAIT);
		cur_byte = head.data;
		phase    = bdiff[1:0];
		n_rs     = head.rs;
		if (s < STEP_BYTE0) begin
			// init region: four steps per init command
			cur_byte = init_cmd(t[4:2]);
			phase    = t[1:0];
			n_rs     = 1'b0;
		end
		case (phase)
			PH_HI_EN: begin
				n_en   = 1'b1;
				n_nib  = cur_byte[7:4];
				n_hold = {6'd0, timing.pulse};
			end
			PH_HI_GAP: begin
				n_en   = 1'b0;
				n_nib  = cur_byte[7:4];
				n_hold = timing.gap;
			end
			PH_LO_EN: begin
				n_en   = 1'b1;
				n_nib  = cur_byte[3:0];
				n_hold = {6'd0, timing.pulse};
			end
			default: begin
				n_en   = 1'b0;
				n_nib  = cur_byte[3:0];
				n_hold = timing.settle;
			end
		endcase
		if (is_wait) begin
			// final wait keeps the pins left by the last init step
			n_en   = 1'b0;
			n_nib  = (s == STEP_FINAL_WAIT) ? 4'h1 : 4'h0;
			n_hold = timing.power;
		end
	end

	assign q_rd = go && (s == STEP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				busy_q      <= (s != STEP_LAST);
				step_q      <= s + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rs_q   <= n_rs;
			en_q   <= n_en;
			nib_q  <= n_nib;
			hold_q <= n_hold;
			last_q <= (s == STEP_LAST);
		end
	end

	assign empty      = !out_valid_q;
	assign reg_select = rs_q;
	assign enable     = en_q;
	assign nibble     = nib_q;
	assign hold_us    = hold_q;
	assign last       = last_q;

	assign status.emit = go;
	assign status.busy = busy_q;
	assign status.step = s;

endmodule

// ===== src/char_lcd_nibble_write_sequencer_top.sv =====
// character lcd sequencer for a 4-bit hd44780-style bus
// input side is a queue: present cmd/value/row/col with push while full is low.
// cmd 0 sends value as a command, cmd 1 as data, cmd 2 moves the cursor to
// row/col; cmd 3 is dropped without any result.
// output side is a queue: while empty is low the oldest pin step is on
// reg_select/enable/nibble/hold_us/last, pop takes it. each item gives four
// steps (high nibble strobe, gap, low nibble strobe, settle); last marks the
// final step of an item.
// the first item after reset is preceded by a power-on wait, the six init
// commands and a final wait: 30 steps for that item.
// the sequencer makes one step per cycle while an item is queued and the
// output register is empty or popped; each push is queued before it is run.
// the front and the sequencer are parted by a small item queue, so push is
// taken while results wait; if pop stays low the output register holds,
// the queue fills and full rises.
// timing registers are written through cfg_valid/cfg_index/cfg_data, always
// ready; reset restores their defaults and queues init for the next item.
module char_lcd_nibble_write_sequencer_top #(
	parameter int QueueDepth = lcdseq_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  value,
	input  logic        row,
	input  logic [5:0]  col,
	output logic        empty,
	input  logic        pop,
	output logic        reg_select,
	output logic        enable,
	output logic [3:0]  nibble,
	output logic [15:0] hold_us,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lcdseq_pkg::*;

	lcdseq_wr_t     wr;
	lcdseq_entry_t  head;
	lcdseq_timing_t timing_q;
	lcdseq_status_t status;
	logic           q_full, q_empty, q_rd, initialized;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.pulse  <= RST_ENABLE_PULSE;
			timing_q.gap    <= RST_NIBBLE_GAP;
			timing_q.settle <= RST_SETTLE;
			timing_q.power  <= RST_POWER_ON;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE_PULSE: timing_q.pulse  <= cfg_data[9:0];
				REG_NIBBLE_GAP:   timing_q.gap    <= cfg_data;
				REG_SETTLE:       timing_q.settle <= cfg_data;
				REG_POWER_ON:     timing_q.power  <= cfg_data;
				default:          ;
			endcase
		end
	end

	lcdseq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (q_full),
		.cmd         (cmd),
		.value       (value),
		.row         (row),
		.col         (col),
		.wr          (wr),
		.initialized (initialized)
	);

	lcdseq_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (q_rd),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	lcdseq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.q_rd       (q_rd),
		.timing     (timing_q),
		.pop        (pop),
		.empty      (empty),
		.reg_select (reg_select),
		.enable     (enable),
		.nibble     (nibble),
		.hold_us    (hold_us),
		.last       (last),
		.status     (status)
	);

	// sequencer mid-item always has its item at the queue head
	a_busy_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !q_empty)
		else $error("sequencer busy with empty queue");

	// init flag only rises after an item carrying the init request
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(initialized) |-> $past(wr.valid && wr.entry.init))
		else $error("init flag set without init item");

	// the queue is released exactly when the final step of an item is emitted
	a_release_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> (!empty && last))
		else $error("item released without its final step");

	// an item without init never starts from the init region
	a_no_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(status.emit && !status.busy && !head.init) |-> (status.step == STEP_BYTE0))
		else $error("byte item started outside byte steps");

endmodule
